FILE: sv/mbrc_pkg.sv
// Shared types, constants and the byte-wide CRC step for the Modbus RTU
// read-holding-registers response checker. No dependencies.
package mbrc_pkg;

  localparam int unsigned MAX_REGISTERS = 125;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [8:0]  POS_MAX = 9'h1FF;
  localparam logic [6:0]  MAX_REG_COUNT = 7'(MAX_REGISTERS);

  typedef enum logic {
    KIND_WORD   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HEADER   = 2'd1,
    ST_CRC      = 2'd2,
    ST_BYTE_CNT = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic [6:0] expected_count;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] word_value;
    logic [6:0]  word_index;
    logic [1:0]  status;
  } out_t;

  // result of one processed byte, with a flag for whether a word is produced
  typedef struct packed {
    logic produced;
    out_t word;
  } res_t;

  // CRC-16/MODBUS over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/mbrc_in_reg.sv
// Input register stage: captures one received byte word and holds it
// until the frame stage consumes it. Uses mbrc_pkg.
module mbrc_in_reg
  import mbrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_word,
  input  logic advance,
  output logic q_valid,
  output in_t  q_word
);

  logic take;

  assign in_stall = q_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (take) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_word <= in_word;
    end
  end

endmodule

FILE: sv/mbrc_frame.sv
// Frame tracker: position, CRC, header check, word assembly and the
// end-of-frame status. Uses mbrc_pkg.
module mbrc_frame
  import mbrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  in_t        item,
  input  logic [7:0] slave_address,
  output res_t       res
);

  logic [8:0]  byte_position, byte_position_next;
  logic [15:0] crc_accumulator, crc_accumulator_next;
  logic [7:0]  byte_count_field, byte_count_field_next;
  logic [7:0]  held_high_byte, held_high_byte_next;
  logic [7:0]  crc_low_received, crc_low_received_next;
  logic        header_mismatch, header_mismatch_next;
  logic [6:0]  requested_count, requested_count_next;
  logic [6:0]  word_counter, word_counter_next;

  logic [8:0]  pos;
  logic [8:0]  data_end;
  logic [8:0]  data_off;
  logic [15:0] crc_cur;
  logic [15:0] crc_upd;
  logic [15:0] crc_got;
  logic        count_ok;
  logic [7:0]  b;

  always_comb begin
    b = item.rx_byte;

    // a start flag opens a fresh frame before the byte is looked at
    if (item.frame_start) begin
      pos                   = '0;
      crc_cur               = CRC_INIT;
      byte_count_field_next = '0;
      held_high_byte_next   = '0;
      crc_low_received_next = '0;
      header_mismatch_next  = 1'b0;
      requested_count_next  = item.expected_count;
      word_counter_next     = '0;
    end else begin
      pos                   = byte_position;
      crc_cur               = crc_accumulator;
      byte_count_field_next = byte_count_field;
      held_high_byte_next   = held_high_byte;
      crc_low_received_next = crc_low_received;
      header_mismatch_next  = header_mismatch;
      requested_count_next  = requested_count;
      word_counter_next     = word_counter;
    end

    data_end = 9'd3 + {1'b0, byte_count_field_next};
    data_off = pos - 9'd3;
    crc_upd  = crc_byte(crc_cur, b);
    crc_accumulator_next = crc_cur;
    crc_got  = {b, crc_low_received_next};
    count_ok = (requested_count_next != '0) &&
               (requested_count_next <= MAX_REG_COUNT) &&
               (byte_count_field_next == {requested_count_next, 1'b0});

    res = '0;

    if (pos == 9'd0) begin
      if (b != slave_address) header_mismatch_next = 1'b1;
      crc_accumulator_next = crc_upd;
    end else if (pos == 9'd1) begin
      if (b != FUNC_READ_HOLDING) header_mismatch_next = 1'b1;
      crc_accumulator_next = crc_upd;
    end else if (pos == 9'd2) begin
      byte_count_field_next = b;
      crc_accumulator_next  = crc_upd;
    end else if (pos < data_end) begin
      crc_accumulator_next = crc_upd;
      if (!data_off[0]) begin
        held_high_byte_next = b;
      end else begin
        res.produced        = 1'b1;
        res.word.kind       = KIND_WORD;
        res.word.word_value = {held_high_byte_next, b};
        res.word.word_index = word_counter_next;
        res.word.status     = ST_OK;
        word_counter_next   = word_counter_next + 7'd1;
      end
    end else if (pos == data_end) begin
      crc_low_received_next = b;
    end else if (pos == data_end + 9'd1) begin
      res.produced    = 1'b1;
      res.word.kind   = KIND_STATUS;
      if (header_mismatch_next) begin
        res.word.status = ST_HEADER;
      end else if (crc_got != crc_cur) begin
        res.word.status = ST_CRC;
      end else if (!count_ok) begin
        res.word.status = ST_BYTE_CNT;
      end else begin
        res.word.status = ST_OK;
      end
    end
    // later positions are surplus bytes: drop them

    byte_position_next = (pos < POS_MAX) ? pos + 9'd1 : pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      crc_accumulator  <= CRC_INIT;
      byte_count_field <= '0;
      held_high_byte   <= '0;
      crc_low_received <= '0;
      header_mismatch  <= 1'b0;
      requested_count  <= 7'd1;
      word_counter     <= '0;
    end else if (advance) begin
      byte_position    <= byte_position_next;
      crc_accumulator  <= crc_accumulator_next;
      byte_count_field <= byte_count_field_next;
      held_high_byte   <= held_high_byte_next;
      crc_low_received <= crc_low_received_next;
      header_mismatch  <= header_mismatch_next;
      requested_count  <= requested_count_next;
      word_counter     <= word_counter_next;
    end
  end

endmodule

FILE: sv/mbrc_out_reg.sv
// Result register: holds one finished result word until downstream takes
// it, and tells the frame stage when it may advance. Uses mbrc_pkg.
module mbrc_out_reg
  import mbrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic advance,
  input  res_t res,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_word
);

  logic load;

  // advance when a byte waits and the result slot is free or being emptied
  assign advance = src_valid && (!out_valid || !out_stall);
  assign load    = advance && res.produced;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= res.word;
    end
  end

endmodule

FILE: sv/modbus_rtu_read_response_checker.sv
// Top level of the Modbus RTU read-holding-registers response checker.
// Instantiates mbrc_in_reg, mbrc_frame and mbrc_out_reg; uses mbrc_pkg.
//
// Feed the response bytes of a function 3 reply one word per handshake,
// with frame_start set on the station address byte and expected_count
// carrying the number of registers that were requested. The block runs
// CRC-16/MODBUS over the header and data, emits each big-endian register
// value with its index as it completes (kind 0), and after the CRC high
// byte emits one status word (kind 1): 0 ok, 1 address or function code
// mismatch, 2 CRC mismatch, 3 byte count not twice a requested count of
// 1 to 125, by that precedence. A lone trailing data byte gives no word,
// bytes after the CRC are dropped until the next start, and a new start
// abandons an open frame silently. Throughput is one byte per clock while
// the output is not stalled: the whole per-byte step, including the
// unrolled eight-bit CRC update, sits between the input register and the
// result register. The input register and the result register each hold
// one word: while a result waits, one more byte is taken into the input
// register, and after that a stall on the output backs up into in_stall
// in the same cycle. Write slave_address (reset 101) only while no frame
// is in flight.
module modbus_rtu_read_response_checker
  import mbrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_word,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic       q_valid;
  in_t        q_word;
  logic       advance;
  res_t       res;
  logic [7:0] slave_address;

  // station address register
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd101;
    end else if (cfg_we) begin
      slave_address <= cfg_wdata;
    end
  end

  mbrc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_word   (q_word)
  );

  mbrc_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .item          (q_word),
    .slave_address (slave_address),
    .res           (res)
  );

  mbrc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .src_valid (q_valid),
    .advance   (advance),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

FILE: tb/sv/modbus_rtu_read_response_checker_tb.sv
`timescale 1ns / 100ps
// Testbench for modbus_rtu_read_response_checker: streams function 3 response
// bytes with random idling and output backpressure, predicts every register
// word and frame status in-line and compares them field by field. Uses mbrc_pkg.
module modbus_rtu_read_response_checker_tb;
  import mbrc_pkg::*;

  localparam int          RANDOM_ITEMS  = 1400;
  localparam int          SETTLE_CYCLES = 6;     // drain time of both registers plus margin
  localparam logic [7:0]  RESET_STATION = 8'd101;
  localparam logic [7:0]  FUNC_EXCEPTION = 8'h83;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_t        in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_word;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  modbus_rtu_read_response_checker uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame parser state, mirrored from the block's behavior.
  logic [7:0]  station_addr;
  logic [8:0]  frame_pos;
  logic [15:0] running_crc;
  logic [7:0]  byte_count;
  logic [7:0]  high_byte;
  logic [7:0]  crc_low;
  logic        header_bad;
  logic [6:0]  regs_requested;
  logic [6:0]  word_idx;

  out_t        results_due[$];   // words and statuses the block still owes
  logic [7:0]  frame_bytes[$];   // bytes of the frame being sent

  int mismatches   = 0;
  int items_sent   = 0;
  int hold_request = 0;          // long receiver hold, picked up by the sink
  bit steady       = 1'b0;       // no idling on either side while set

  // Bit-serial CRC-16/MODBUS, one byte LSB first.
  function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                    input logic [7:0]  b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void open_frame(input logic [6:0] count);
    frame_pos      = '0;
    running_crc    = CRC_INIT;
    byte_count     = '0;
    high_byte      = '0;
    crc_low        = '0;
    header_bad     = 1'b0;
    regs_requested = count;
    word_idx       = '0;
  endfunction

  // Advance the parser by one accepted byte and queue whatever it produces.
  function automatic void parse_response_byte(input in_t w);
    out_t        r;
    int          data_end;
    logic [15:0] got;
    status_t     st;
    bit          count_ok;
    if (w.frame_start) begin
      open_frame(w.expected_count);
    end
    data_end = 3 + byte_count;   // position of the CRC low byte
    r = '0;
    if (frame_pos == 0) begin
      if (w.rx_byte != station_addr) begin
        header_bad = 1'b1;
      end
      running_crc = crc16_modbus_step(running_crc, w.rx_byte);
    end else if (frame_pos == 1) begin
      if (w.rx_byte != FUNC_READ_HOLDING) begin
        header_bad = 1'b1;
      end
      running_crc = crc16_modbus_step(running_crc, w.rx_byte);
    end else if (frame_pos == 2) begin
      byte_count  = w.rx_byte;
      running_crc = crc16_modbus_step(running_crc, w.rx_byte);
    end else if (frame_pos < data_end) begin
      running_crc = crc16_modbus_step(running_crc, w.rx_byte);
      // data starts at position 3: odd positions carry the high byte
      if (frame_pos[0]) begin
        high_byte = w.rx_byte;
      end else begin
        r.kind       = KIND_WORD;
        r.word_value = {high_byte, w.rx_byte};
        r.word_index = word_idx;
        r.status     = ST_OK;
        results_due.push_back(r);
        word_idx = word_idx + 7'd1;
      end
    end else if (frame_pos == data_end) begin
      crc_low = w.rx_byte;
    end else if (frame_pos == data_end + 1) begin
      got      = {w.rx_byte, crc_low};
      count_ok = regs_requested >= 1 && regs_requested <= MAX_REGISTERS &&
                 byte_count == 2 * regs_requested;
      if (header_bad) begin
        st = ST_HEADER;
      end else if (got != running_crc) begin
        st = ST_CRC;
      end else if (!count_ok) begin
        st = ST_BYTE_CNT;
      end else begin
        st = ST_OK;
      end
      r.kind   = KIND_STATUS;
      r.status = st;
      results_due.push_back(r);
    end
    // anything further is surplus and dropped
    if (frame_pos != POS_MAX) begin
      frame_pos = frame_pos + 9'd1;
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Fill frame_bytes with header, data and CRC (low byte first).
  function automatic void build_frame(input logic [7:0] addr, input logic [7:0] func,
                                      input logic [7:0] n_field, input int data_len,
                                      input bit bad_crc);
    logic [15:0] c;
    frame_bytes.delete();
    frame_bytes.push_back(addr);
    frame_bytes.push_back(func);
    frame_bytes.push_back(n_field);
    for (int i = 0; i < data_len; i++) begin
      frame_bytes.push_back(pick_byte());
    end
    c = CRC_INIT;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      c = crc16_modbus_step(c, frame_bytes[i]);
    end
    if (bad_crc) begin
      c = c ^ 16'($urandom_range(1, 65535));
    end
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Offer one word after a random gap; predict it once the handshake is sure.
  // Handshake signals are sampled at the falling edge, where they are stable.
  task automatic send_word(input in_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
    end while (in_stall);
    parse_response_byte(w);
    items_sent++;
    @(posedge clk);
  endtask

  // Send frame_bytes; the count only matters on the start byte, so
  // randomize it elsewhere to toggle every bit.
  task automatic send_frame(input bit with_start, input logic [6:0] count);
    in_t w;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      w.rx_byte        = frame_bytes[i];
      w.frame_start    = with_start && i == 0;
      w.expected_count = (i == 0) ? count : 7'($urandom_range(0, 127));
      send_word(w);
    end
  endtask

  // Drop valid, wait until every owed result is back, then let the pipe empty.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_station_address(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    station_addr = v;
  endtask

  // Mostly well-formed frames with random content; the rest breaks one rule.
  task automatic random_frame();
    int         pick;
    int         cut;
    int         surplus;
    logic [7:0] addr;
    logic [7:0] func;
    logic [7:0] n_field;
    logic [6:0] count;
    bit         bad_crc;
    bit         with_start;
    in_t        w;
    pick       = $urandom_range(0, 99);
    count      = ($urandom_range(0, 99) == 0) ? 7'(MAX_REGISTERS) : 7'($urandom_range(1, 8));
    addr       = station_addr;
    func       = FUNC_READ_HOLDING;
    n_field    = 8'(2 * count);
    bad_crc    = 1'b0;
    with_start = 1'b1;
    cut        = 0;
    surplus    = 0;
    if (pick < 70) begin
      // well formed
    end else if (pick < 74) begin
      addr = 8'($urandom_range(0, 255));
    end else if (pick < 78) begin
      func = $urandom_range(0, 1) ? FUNC_EXCEPTION : 8'($urandom_range(0, 255));
    end else if (pick < 82) begin
      bad_crc = 1'b1;
    end else if (pick < 86) begin
      n_field = 8'($urandom_range(0, 20));
    end else if (pick < 89) begin
      count   = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(126, 127));
      n_field = $urandom_range(0, 1) ? 8'(2 * count) : 8'($urandom_range(0, 8));
    end else if (pick < 93) begin
      cut = 1;
    end else if (pick < 96) begin
      surplus = $urandom_range(1, 3);
    end else if (pick < 98) begin
      with_start = 1'b0;
    end else begin
      // raw noise, start flag included
      repeat ($urandom_range(1, 3)) begin
        w = in_t'(16'($urandom));
        send_word(w);
      end
      return;
    end
    build_frame(addr, func, n_field, n_field, bad_crc);
    if (cut != 0) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) frame_bytes.delete(frame_bytes.size() - 1);
    end
    repeat (surplus) frame_bytes.push_back(8'($urandom_range(0, 255)));
    send_frame(with_start, count);
  endtask

  // Bytes before any start form a frame already open with one register.
  task automatic test_headless_bytes();
    build_frame(station_addr, FUNC_READ_HOLDING, 8'd2, 2, 1'b0);
    send_frame(1'b0, 7'd1);
    settle_block();
  endtask

  // Surplus byte, a frame abandoned by a new start, and a zero count.
  task automatic test_restart_and_surplus();
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom_range(0, 255)));
    send_frame(1'b0, 7'd1);
    build_frame(station_addr, FUNC_READ_HOLDING, 8'd254, 254, 1'b0);
    while (frame_bytes.size() > 2) frame_bytes.delete(frame_bytes.size() - 1);
    send_frame(1'b1, 7'd127);
    build_frame(station_addr, FUNC_READ_HOLDING, 8'd0, 0, 1'b0);
    send_frame(1'b1, 7'd0);
    settle_block();
  endtask

  // Header error beats CRC error, CRC error beats a count error; odd byte count.
  task automatic test_error_precedence();
    build_frame(~station_addr, FUNC_EXCEPTION, 8'd1, 1, 1'b1);
    send_frame(1'b1, 7'd1);
    build_frame(station_addr, FUNC_READ_HOLDING, 8'd0, 0, 1'b1);
    send_frame(1'b1, 7'd127);
    settle_block();
  endtask

  task automatic test_address_settings();
    logic [7:0] addrs[3];
    addrs[0] = 8'h00;
    addrs[1] = 8'hFF;
    addrs[2] = 8'($urandom_range(1, 254));
    for (int i = 0; i < 3; i++) begin
      write_station_address(addrs[i]);
      repeat (3) random_frame();
      settle_block();
    end
  endtask

  // Hold the output for a long stretch behind a maximum-size frame sent
  // back to back, so both registers fill and the input stalls.
  task automatic test_backpressure();
    steady       = 1'b1;
    hold_request = 400;
    build_frame(station_addr, FUNC_READ_HOLDING, 8'(2 * MAX_REGISTERS), 2 * MAX_REGISTERS,
                1'b0);
    send_frame(1'b1, 7'(MAX_REGISTERS));
    steady = 1'b0;
    settle_block();
  endtask

  // Batches of random frames, a fresh station address now and then, and
  // some batches with no idling at all.
  task automatic test_random_frames();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      settle_block();
      case ($urandom_range(0, 5))
        0:       write_station_address(8'h00);
        1:       write_station_address(8'hFF);
        2, 3:    write_station_address(8'($urandom_range(0, 255)));
        default: ;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      repeat (10) random_frame();
      // close the batch with a clean frame so no frame stays open
      build_frame(station_addr, FUNC_READ_HOLDING, 8'd2, 2, 1'b0);
      send_frame(1'b1, 7'd1);
    end
    steady = 1'b0;
  endtask

  // Result side: random stall per word, plus the long hold on request.
  initial begin : result_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_stall <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
      end while (!out_valid);
      @(posedge clk);
    end
  end

  // Compare each word that will be taken at the next edge with the oldest
  // owed result.
  always @(negedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %h index %0d status %0d",
                                  out_word.kind, out_word.word_value, out_word.word_index,
                                  out_word.status));
      end else begin
        want = results_due.pop_front();
        if (out_word.kind !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", out_word.kind, want.kind));
        if (out_word.word_value !== want.word_value)
          report_mismatch($sformatf("word_value got %h want %h", out_word.word_value,
                                    want.word_value));
        if (out_word.word_index !== want.word_index)
          report_mismatch($sformatf("word_index got %0d want %0d", out_word.word_index,
                                    want.word_index));
        if (out_word.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_word.status,
                                    want.status));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL modbus_rtu_read_response_checker");
    $finish;
  end

  initial begin
    station_addr = RESET_STATION;
    open_frame(7'd1);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_headless_bytes();
    test_restart_and_surplus();
    test_error_precedence();
    test_address_settings();
    test_backpressure();
    test_random_frames();
    settle_block();
    if (mismatches == 0) begin
      $display("PASS modbus_rtu_read_response_checker");
    end else begin
      $display("FAIL modbus_rtu_read_response_checker");
    end
    $finish;
  end

endmodule
